/* rtl/core/axm_pkg.sv */
// Shared types, constants and AES round functions for the XCBC-MAC-96 engine.
package axm_pkg;

    localparam int KEY_BYTES  = 16;
    localparam int AES_ROUNDS = 10;
    localparam int BLK_BYTES  = 16;

    // Configuration register indexes
    localparam logic CFG_KEY_HI = 1'b0;
    localparam logic CFG_KEY_LO = 1'b1;

    // Datapath operation codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_ROUND = 2'd2;
    localparam logic [1:0] OP_FIN   = 2'd3;

    // Key slot: message pass, or derivation of K1, K2, K3
    localparam logic [1:0] KSEL_MSG = 2'd0;
    localparam logic [1:0] KSEL_K1  = 2'd1;
    localparam logic [1:0] KSEL_K2  = 2'd2;
    localparam logic [1:0] KSEL_K3  = 2'd3;

    typedef struct packed {
        logic       cap_in;    // latch the accepted request
        logic [1:0] op;        // datapath operation
        logic [1:0] ksel;      // key slot for load / save
        logic       final_rnd; // last AES round (no MixColumns)
        logic       save_key;  // store round output as derived key
    } t_dp_cmd;

    typedef struct packed {
        logic last; // latched request is the last block
    } t_dp_sts;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns (skipped on final), AddRoundKey
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic fin);
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, all;
        logic [127:0] o;
        int           c, i;
        for (c = 0; c < 4; c++) begin
            for (i = 0; i < 4; i++) begin
                t[4*c+i] = SBOX[s[127-8*(4*((c+i)&3)+i) -: 8]];
            end
        end
        for (c = 0; c < 4; c++) begin
            a0  = t[4*c];
            a1  = t[4*c+1];
            a2  = t[4*c+2];
            a3  = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (fin) begin
                o[127-8*(4*c)   -: 8] = a0;
                o[127-8*(4*c+1) -: 8] = a1;
                o[127-8*(4*c+2) -: 8] = a2;
                o[127-8*(4*c+3) -: 8] = a3;
            end else begin
                o[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
                o[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
                o[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
                o[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        return o ^ rk;
    endfunction

    // Next AES-128 round key from the current one
    function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] t, n0, n1, n2, n3;
        t  = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        n0 = rk[127:96] ^ t;
        n1 = rk[95:64] ^ n0;
        n2 = rk[63:32] ^ n1;
        n3 = rk[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

/* rtl/core/aes_xcbc_mac96_engine_core.sv */
// Top level of the AES-XCBC-MAC-96 engine: controller plus datapath.
//
// Usage:
//   Write the 128-bit key through the config port (index 0 = upper 64 bits,
//   index 1 = lower 64 bits) while the engine is idle. Then send message
//   blocks on the input channel (valid/stall); last_block marks the final
//   block and valid_bytes gives its length (0 = empty message, 16+ = full).
//   One 96-bit tag leaves on the output channel per message.
// Sequence:
//   A request runs through accept, key load, ten AES rounds through the
//   single round unit (key schedule computed alongside), and a finish step.
//   The tag appears the cycle after the finish. The first block after reset
//   or a key write first runs three AES encryptions for K1, K2, K3.
// Reset and back-pressure:
//   Reset clears the key, the chaining value and the derived-key flag.
//   The tag sits in an output register; a new request is accepted while it
//   waits, but the next tag holds in the finish state until it is taken.
module aes_xcbc_mac96_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_block_hi,
    input  logic [63:0] i_block_lo,
    input  logic [4:0]  i_valid_bytes,
    input  logic        i_last_block,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_mac_hi,
    output logic [31:0] o_mac_lo
);
    import axm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    axm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Cipher datapath
    axm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_block_hi    (i_block_hi),
        .i_block_lo    (i_block_lo),
        .i_valid_bytes (i_valid_bytes),
        .i_last_block  (i_last_block),
        .o_mac_hi      (o_mac_hi),
        .o_mac_lo      (o_mac_lo)
    );

endmodule

/* rtl/core/axm_dp.sv */
// Datapath: key registers, round unit with on-the-fly key schedule, chaining and tag.
module axm_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  axm_pkg::t_dp_cmd i_cmd,
    output axm_pkg::t_dp_sts o_sts,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [63:0]      i_cfg_wdata,
    input  logic [63:0]      i_block_hi,
    input  logic [63:0]      i_block_lo,
    input  logic [4:0]       i_valid_bytes,
    input  logic             i_last_block,
    output logic [63:0]      o_mac_hi,
    output logic [31:0]      o_mac_lo
);
    import axm_pkg::*;

    logic [127:0] r_key, r_k1, r_k2, r_k3, r_s, r_rk, r_chain, r_blk;
    logic [7:0]   r_rcon;
    logic [4:0]   r_nbytes;
    logic         r_last;
    logic [63:0]  r_mac_hi;
    logic [31:0]  r_mac_lo;

    logic [127:0] pad_blk, msg_blk, rk_nx, rnd_out;

    // Short last block: keep counted bytes, append 0x80, zero the rest
    always_comb begin
        for (int i = 0; i < BLK_BYTES; i++) begin
            if (5'(i) < r_nbytes) begin
                pad_blk[127-8*i -: 8] = r_blk[127-8*i -: 8];
            end else if (5'(i) == r_nbytes) begin
                pad_blk[127-8*i -: 8] = 8'h80;
            end else begin
                pad_blk[127-8*i -: 8] = 8'h00;
            end
        end
    end

    // Block entering the cipher, before chaining
    always_comb begin
        if (!r_last) begin
            msg_blk = r_blk;
        end else if (r_nbytes >= 5'(BLK_BYTES)) begin
            msg_blk = r_blk ^ r_k2;
        end else begin
            msg_blk = pad_blk ^ r_k3;
        end
    end

    assign rk_nx   = key_next(r_rk, r_rcon);
    assign rnd_out = aes_round(r_s, rk_nx, i_cmd.final_rnd);

    // Key registers and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_chain <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_KEY_LO) begin
                    r_key[63:0] <= i_cfg_wdata;
                end else begin
                    r_key[127:64] <= i_cfg_wdata;
                end
            end
            if (i_cmd.op == OP_FIN) begin
                r_chain <= r_last ? '0 : r_s;
            end
        end
    end

    // Request capture, cipher state and derived keys
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_blk    <= {i_block_hi, i_block_lo};
            r_nbytes <= i_valid_bytes;
            r_last   <= i_last_block;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_rcon <= 8'h01;
                if (i_cmd.ksel == KSEL_MSG) begin
                    r_s  <= msg_blk ^ r_chain ^ r_k1;
                    r_rk <= r_k1;
                end else begin
                    r_s  <= {BLK_BYTES{6'd0, i_cmd.ksel}} ^ r_key;
                    r_rk <= r_key;
                end
            end
            OP_ROUND: begin
                r_s    <= rnd_out;
                r_rk   <= rk_nx;
                r_rcon <= xtime(r_rcon);
                if (i_cmd.save_key) begin
                    case (i_cmd.ksel)
                        KSEL_K1: r_k1 <= rnd_out;
                        KSEL_K2: r_k2 <= rnd_out;
                        KSEL_K3: r_k3 <= rnd_out;
                        default: ;
                    endcase
                end
            end
            OP_FIN: begin
                if (r_last) begin
                    r_mac_hi <= r_s[127:64];
                    r_mac_lo <= r_s[63:32];
                end
            end
            default: ;
        endcase
    end

    assign o_sts.last = r_last;
    assign o_mac_hi   = r_mac_hi;
    assign o_mac_lo   = r_mac_lo;

endmodule

/* rtl/core/axm_ctrl.sv */
// Controller: sequences key derivation, AES rounds and result hand-off.
module axm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  logic             i_cfg_we,
    input  axm_pkg::t_dp_sts i_sts,
    output axm_pkg::t_dp_cmd o_cmd
);
    import axm_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] r_state, n_state;
    logic [3:0] r_round, n_round;
    logic [1:0] r_phase, n_phase;
    logic       r_derived, n_derived;
    logic       r_out_valid, n_out_valid;
    logic       in_acc, fin_ok;

    assign in_acc = i_in_valid && (r_state == S_IDLE);
    assign fin_ok = !i_sts.last || !r_out_valid || !i_out_stall;

    // Next-state and command logic
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_phase     = r_phase;
        n_derived   = r_derived;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.ksel  = r_phase;
        o_cmd.cap_in = in_acc;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_phase = r_derived ? KSEL_MSG : KSEL_K1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_round  = 4'd1;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.op        = OP_ROUND;
                o_cmd.final_rnd = (r_round == 4'(AES_ROUNDS));
                o_cmd.save_key  = o_cmd.final_rnd && (r_phase != KSEL_MSG);
                n_round         = r_round + 4'd1;
                if (o_cmd.final_rnd) begin
                    if (r_phase == KSEL_MSG) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_LOAD;
                        if (r_phase == KSEL_K3) begin
                            n_phase   = KSEL_MSG;
                            n_derived = 1'b1;
                        end else begin
                            n_phase = r_phase + 2'd1;
                        end
                    end
                end
            end
            S_FIN: begin
                if (fin_ok) begin
                    o_cmd.op = OP_FIN;
                    n_state  = S_IDLE;
                    if (i_sts.last) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // a key write invalidates derived keys
        if (i_cfg_we) begin
            n_derived = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_phase     <= KSEL_MSG;
            r_derived   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_phase     <= n_phase;
            r_derived   <= n_derived;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= 4'(AES_ROUNDS + 1))
        else $error("round counter out of range");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside finish state");
    a_msg_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == 4'(AES_ROUNDS) && r_phase == KSEL_MSG)
        |=> r_state == S_FIN)
        else $error("message pass did not finish");
    a_derive_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_derived) |=> r_phase == KSEL_K1)
        else $error("request taken without key derivation");
`endif

endmodule
